### rtl/core/ffha_pkg.sv
// Shared constants, codes and controller/datapath interface types of the heap allocator.
package ffha_pkg;

   localparam int HEAP_GRANULES_DEF = 4096;
   localparam int HEADER_BYTES_DEF  = 32;

   localparam int ADDR_W  = 48;
   localparam int REQ_W   = 32;
   localparam int BYTES_W = 16;
   localparam int CSR_IDX_W = 2;

   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BASE  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_HEAP_BYTES = 2'd1;

   localparam logic MODE_ALLOC = 1'b0;
   localparam logic MODE_FREE  = 1'b1;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_NO_MEM  = 2'd1,
      ST_ZERO    = 2'd2,
      ST_BAD_ADR = 2'd3
   } status_type;

   typedef enum logic [4:0] {
      OP_IDLE, OP_INIT, OP_LOAD, OP_PREP, OP_CHK, OP_RD_G, OP_RD_T, OP_RD_N,
      OP_ASTEP, OP_SPLIT, OP_TAKE, OP_GRANT, OP_FSTEP, OP_FREE_B, OP_ADD_N,
      OP_FWR, OP_OUT
   } op_type;

   typedef enum logic [3:0] {
      S_INIT, S_IDLE, S_PREP, S_CHK, S_ARD, S_AEV, S_GRANT, S_FWALK, S_FEV,
      S_FTEV, S_FN, S_FNEV, S_FWR, S_OUT
   } state_type;

   typedef struct packed {
      op_type     op;
      status_type code;
   } cmd_type;

   typedef struct packed {
      logic is_free;
      logic req_zero;
      logic heap_on;
      logic rel_zero;
      logic off_bad;
      logic g_end;
      logic g_lt_t;
      logic g_eq_t;
      logic rd_used;
      logic rd_size_zero;
      logic fit;
      logic split;
      logic n_lt_gc;
      logic out_free;
      logic csr_hit;
   } flags_type;

endpackage

### rtl/core/first_fit_heap_allocator_top.sv
// Top level of the first-fit heap allocator with block coalescing.
//
// The heap is a run of 8-byte granules kept as address-ordered blocks with
// headers. A request transfer on the req_ channel carries either an allocate
// (tuser low) or a free (tuser high); each request produces exactly one
// response transfer on the rsp_ channel with a status, the granted address,
// and the used and free byte totals after the request.
// Each walked block costs one table read and one evaluation step on the
// block table; an allocate walks the blocks up to the first fit, and a
// free walks the blocks in front of the released one.
// One request is worked on at a time; a new request is taken while the
// previous response still waits in the output register, and its result is
// held back until that response transfer has happened.
// Reset, and any write of heap_base or heap_bytes on the csr_ channel,
// rebuild the heap as one free block and clear the used total.
// While rsp_tready is low, the response stays valid and unchanged.
module first_fit_heap_allocator_top #(
   parameter int HEAP_GRANULES = ffha_pkg::HEAP_GRANULES_DEF,
   parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                           clock,
   input  logic                           reset,
   input  logic                           req_tvalid,
   output logic                           req_tready,
   input  logic [79:0]                    req_tdata,   // request_bytes, release_address
   input  logic                           req_tuser,   // mode
   output logic                           rsp_tvalid,
   input  logic                           rsp_tready,
   output logic [87:0]                    rsp_tdata,   // status, granted_address, used_bytes, free_bytes
   input  logic                           csr_valid,
   output logic                           csr_ready,
   input  logic [ffha_pkg::CSR_IDX_W-1:0] csr_index,
   input  logic [ffha_pkg::ADDR_W-1:0]    csr_data
);

   ffha_pkg::cmd_type   cmd;
   ffha_pkg::flags_type flags;

   // Register writes are always taken; the user must send them only while idle, unchecked by the block.
   assign csr_ready = 1'b1;

   ffha_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .flags      (flags),
      .cmd        (cmd)
   );

   ffha_dp #(
      .HEAP_GRANULES (HEAP_GRANULES),
      .HEADER_BYTES  (HEADER_BYTES)
   ) u_dp (
      .clock      (clock),
      .reset      (reset),
      .cmd        (cmd),
      .flags      (flags),
      .req_bytes  (req_tdata[31:0]),
      .req_addr   (req_tdata[79:32]),
      .req_mode   (req_tuser),
      .csr_valid  (csr_valid),
      .csr_index  (csr_index),
      .csr_data   (csr_data),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule

### rtl/core/ffha_dp.sv
// Datapath of the heap allocator: block table memory, walk registers and result register.
module ffha_dp #(
   parameter int HEAP_GRANULES = ffha_pkg::HEAP_GRANULES_DEF,
   parameter int HEADER_BYTES  = ffha_pkg::HEADER_BYTES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  ffha_pkg::cmd_type                 cmd,
   output ffha_pkg::flags_type               flags,
   input  logic [ffha_pkg::REQ_W-1:0]        req_bytes,
   input  logic [ffha_pkg::ADDR_W-1:0]       req_addr,
   input  logic                              req_mode,
   input  logic                              csr_valid,
   input  logic [ffha_pkg::CSR_IDX_W-1:0]    csr_index,
   input  logic [ffha_pkg::ADDR_W-1:0]       csr_data,
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [87:0]                       rsp_tdata
);

   localparam int GW   = $clog2(HEAP_GRANULES + 1);
   localparam int AW   = $clog2(HEAP_GRANULES);
   localparam int HDR  = (HEADER_BYTES + 7) / 8;
   localparam int CAPB = HEAP_GRANULES * 8;
   localparam int NW   = 31;
   localparam int GIW  = ffha_pkg::ADDR_W - 3;

   // Table entry: used flag on top, block size in granules below.
   logic [GW:0] mem [HEAP_GRANULES];
   logic [GW:0] rd_ff;

   logic [ffha_pkg::ADDR_W-1:0]  base_ff;
   logic [ffha_pkg::BYTES_W-1:0] hbytes_ff;
   logic                         mode_ff;
   logic [ffha_pkg::REQ_W-1:0]   req_ff;
   logic [ffha_pkg::ADDR_W-1:0]  rel_ff;
   logic [ffha_pkg::ADDR_W-1:0]  off_ff;
   logic [NW-1:0]                need_ff;
   logic [GW-1:0] g_ff, t_ff, n_ff, prev_ff, prev_size_ff, bsize_ff, used_ff;
   logic          has_prev_ff, prev_used_ff;
   logic [ffha_pkg::ADDR_W-1:0]  gaddr_ff;

   logic                          rsp_valid_ff;
   logic [1:0]                    rsp_status_ff;
   logic [ffha_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [ffha_pkg::BYTES_W-1:0]  rsp_used_ff, rsp_free_ff;

   logic [31:0]   cap;
   logic          heap_on;
   logic [GW-1:0] gc;
   logic [GW-1:0] rd_size;
   logic          rd_used;
   logic [GIW-1:0] gi, tw;
   logic          csr_hit;
   logic          we, re;
   logic [AW-1:0] wa, ra;
   logic [GW:0]   wd;
   logic [GW-1:0] need_g;

   always_comb begin
      cap     = (32'(hbytes_ff) > 32'(CAPB)) ? 32'(CAPB) : 32'(hbytes_ff);
      heap_on = (cap >= 32'(2 * HEADER_BYTES)) && (cap[31:3] != 29'd0);
      gc      = heap_on ? GW'(cap >> 3) : '0;
   end

   assign rd_size = rd_ff[GW-1:0];
   assign rd_used = rd_ff[GW];
   assign gi      = off_ff[ffha_pkg::ADDR_W-1:3];
   assign tw      = gi - GIW'(HDR);
   assign need_g  = need_ff[GW-1:0];
   assign csr_hit = csr_valid && (csr_index == ffha_pkg::CSR_HEAP_BASE ||
                                  csr_index == ffha_pkg::CSR_HEAP_BYTES);

   always_comb begin
      flags.is_free      = (mode_ff == ffha_pkg::MODE_FREE);
      flags.req_zero     = (req_ff == '0);
      flags.heap_on      = heap_on;
      flags.rel_zero     = (rel_ff == '0);
      flags.off_bad      = (off_ff[2:0] != 3'd0) || (gi < GIW'(HDR)) || (tw >= GIW'(gc));
      flags.g_end        = (g_ff >= gc);
      flags.g_lt_t       = (g_ff < t_ff);
      flags.g_eq_t       = (g_ff == t_ff);
      flags.rd_used      = rd_used;
      flags.rd_size_zero = (rd_size == '0);
      flags.fit          = !rd_used && (NW'(rd_size) >= need_ff);
      flags.split        = NW'(rd_size) >= need_ff + NW'(HDR + 1);
      flags.n_lt_gc      = (n_ff < gc);
      flags.out_free     = !rsp_valid_ff || rsp_tready;
      flags.csr_hit      = csr_hit;
   end

   // Memory port control.
   always_comb begin
      we = 1'b0;
      re = 1'b0;
      wa = '0;
      ra = '0;
      wd = '0;
      case (cmd.op)
         ffha_pkg::OP_INIT: begin
            we = 1'b1;
            wd = {1'b0, gc};
         end
         ffha_pkg::OP_RD_G: begin
            re = 1'b1;
            ra = g_ff[AW-1:0];
         end
         ffha_pkg::OP_RD_T: begin
            re = 1'b1;
            ra = t_ff[AW-1:0];
         end
         ffha_pkg::OP_RD_N: begin
            re = 1'b1;
            ra = n_ff[AW-1:0];
         end
         ffha_pkg::OP_SPLIT: begin
            we = 1'b1;
            wa = AW'(g_ff + need_g);
            wd = {1'b0, rd_size - need_g};
         end
         ffha_pkg::OP_GRANT: begin
            we = 1'b1;
            wa = g_ff[AW-1:0];
            wd = {1'b1, bsize_ff};
         end
         ffha_pkg::OP_FWR: begin
            we = 1'b1;
            if (has_prev_ff && !prev_used_ff) begin
               wa = prev_ff[AW-1:0];
               wd = {1'b0, prev_size_ff + bsize_ff};
            end else begin
               wa = t_ff[AW-1:0];
               wd = {1'b0, bsize_ff};
            end
         end
         default: begin
            we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (we) begin
         mem[wa] <= wd;
      end
      if (re) begin
         rd_ff <= mem[ra];
      end
   end

   // Configuration, accounting and response valid registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         base_ff      <= '0;
         hbytes_ff    <= 16'd32768;
         used_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (csr_hit) begin
            used_ff <= '0;
            if (csr_index == ffha_pkg::CSR_HEAP_BASE) begin
               base_ff <= {csr_data[ffha_pkg::ADDR_W-1:3], 3'b000};
            end else begin
               hbytes_ff <= csr_data[ffha_pkg::BYTES_W-1:0];
            end
         end else begin
            case (cmd.op)
               ffha_pkg::OP_GRANT:  used_ff <= used_ff + bsize_ff;
               ffha_pkg::OP_FREE_B: used_ff <= used_ff - rd_size;
               default: begin
               end
            endcase
         end
         if (cmd.op == ffha_pkg::OP_OUT) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (cmd.op)
         ffha_pkg::OP_LOAD: begin
            mode_ff <= req_mode;
            req_ff  <= req_bytes;
            rel_ff  <= req_addr;
         end
         ffha_pkg::OP_PREP: begin
            need_ff     <= NW'((33'(req_ff) + 33'd7) >> 3) + NW'(HDR);
            off_ff      <= rel_ff - base_ff;
            g_ff        <= '0;
            has_prev_ff <= 1'b0;
            gaddr_ff    <= '0;
         end
         ffha_pkg::OP_CHK:   t_ff <= GW'(tw);
         ffha_pkg::OP_ASTEP: g_ff <= g_ff + rd_size;
         ffha_pkg::OP_SPLIT: bsize_ff <= need_g;
         ffha_pkg::OP_TAKE:  bsize_ff <= rd_size;
         ffha_pkg::OP_GRANT: begin
            gaddr_ff <= base_ff + ffha_pkg::ADDR_W'({g_ff + GW'(HDR), 3'b000});
         end
         ffha_pkg::OP_FSTEP: begin
            prev_ff      <= g_ff;
            prev_used_ff <= rd_used;
            prev_size_ff <= rd_size;
            has_prev_ff  <= 1'b1;
            g_ff         <= g_ff + rd_size;
         end
         ffha_pkg::OP_FREE_B: begin
            bsize_ff <= rd_size;
            n_ff     <= t_ff + rd_size;
         end
         ffha_pkg::OP_ADD_N: bsize_ff <= bsize_ff + rd_size;
         ffha_pkg::OP_OUT: begin
            rsp_status_ff <= cmd.code;
            rsp_addr_ff   <= gaddr_ff;
            rsp_used_ff   <= 16'({used_ff, 3'b000});
            rsp_free_ff   <= 16'({gc - used_ff, 3'b000});
         end
         default: begin
         end
      endcase
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {6'd0, rsp_free_ff, rsp_used_ff, rsp_addr_ff, rsp_status_ff};

endmodule

### rtl/core/ffha_ctrl.sv
// Controller state machine of the heap allocator: sequences the block walks.
module ffha_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_tvalid,
   output logic                req_tready,
   input  ffha_pkg::flags_type flags,
   output ffha_pkg::cmd_type   cmd
);

   ffha_pkg::state_type  state_ff, state_in;
   ffha_pkg::status_type code_ff, code_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ffha_pkg::S_INIT;
         code_ff  <= ffha_pkg::ST_OK;
      end else begin
         state_ff <= state_in;
         code_ff  <= code_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      code_in    = code_ff;
      cmd.op     = ffha_pkg::OP_IDLE;
      cmd.code   = code_ff;
      req_tready = 1'b0;
      case (state_ff)
         ffha_pkg::S_INIT: begin
            cmd.op   = ffha_pkg::OP_INIT;
            state_in = ffha_pkg::S_IDLE;
         end
         ffha_pkg::S_IDLE: begin
            req_tready = 1'b1;
            if (req_tvalid) begin
               cmd.op   = ffha_pkg::OP_LOAD;
               state_in = ffha_pkg::S_PREP;
            end
         end
         ffha_pkg::S_PREP: begin
            cmd.op   = ffha_pkg::OP_PREP;
            state_in = ffha_pkg::S_CHK;
         end
         ffha_pkg::S_CHK: begin
            state_in = ffha_pkg::S_OUT;
            if (!flags.is_free) begin
               if (flags.req_zero) begin
                  code_in = ffha_pkg::ST_ZERO;
               end else if (!flags.heap_on) begin
                  code_in = ffha_pkg::ST_NO_MEM;
               end else begin
                  state_in = ffha_pkg::S_ARD;
               end
            end else if (flags.rel_zero) begin
               code_in = ffha_pkg::ST_OK;
            end else if (!flags.heap_on || flags.off_bad) begin
               code_in = ffha_pkg::ST_BAD_ADR;
            end else begin
               cmd.op   = ffha_pkg::OP_CHK;
               state_in = ffha_pkg::S_FWALK;
            end
         end
         ffha_pkg::S_ARD: begin
            if (flags.g_end) begin
               code_in  = ffha_pkg::ST_NO_MEM;
               state_in = ffha_pkg::S_OUT;
            end else begin
               cmd.op   = ffha_pkg::OP_RD_G;
               state_in = ffha_pkg::S_AEV;
            end
         end
         ffha_pkg::S_AEV: begin
            if (flags.rd_size_zero) begin
               code_in  = ffha_pkg::ST_NO_MEM;
               state_in = ffha_pkg::S_OUT;
            end else if (flags.fit) begin
               cmd.op   = flags.split ? ffha_pkg::OP_SPLIT : ffha_pkg::OP_TAKE;
               state_in = ffha_pkg::S_GRANT;
            end else begin
               cmd.op   = ffha_pkg::OP_ASTEP;
               state_in = ffha_pkg::S_ARD;
            end
         end
         ffha_pkg::S_GRANT: begin
            cmd.op   = ffha_pkg::OP_GRANT;
            code_in  = ffha_pkg::ST_OK;
            state_in = ffha_pkg::S_OUT;
         end
         ffha_pkg::S_FWALK: begin
            if (flags.g_lt_t) begin
               cmd.op   = ffha_pkg::OP_RD_G;
               state_in = ffha_pkg::S_FEV;
            end else if (flags.g_eq_t) begin
               cmd.op   = ffha_pkg::OP_RD_T;
               state_in = ffha_pkg::S_FTEV;
            end else begin
               code_in  = ffha_pkg::ST_BAD_ADR;
               state_in = ffha_pkg::S_OUT;
            end
         end
         ffha_pkg::S_FEV: begin
            if (flags.rd_size_zero) begin
               code_in  = ffha_pkg::ST_BAD_ADR;
               state_in = ffha_pkg::S_OUT;
            end else begin
               cmd.op   = ffha_pkg::OP_FSTEP;
               state_in = ffha_pkg::S_FWALK;
            end
         end
         ffha_pkg::S_FTEV: begin
            code_in = ffha_pkg::ST_OK;
            if (!flags.rd_used) begin
               state_in = ffha_pkg::S_OUT;
            end else begin
               cmd.op   = ffha_pkg::OP_FREE_B;
               state_in = ffha_pkg::S_FN;
            end
         end
         ffha_pkg::S_FN: begin
            if (flags.n_lt_gc) begin
               cmd.op   = ffha_pkg::OP_RD_N;
               state_in = ffha_pkg::S_FNEV;
            end else begin
               state_in = ffha_pkg::S_FWR;
            end
         end
         ffha_pkg::S_FNEV: begin
            if (!flags.rd_used) begin
               cmd.op = ffha_pkg::OP_ADD_N;
            end
            state_in = ffha_pkg::S_FWR;
         end
         ffha_pkg::S_FWR: begin
            cmd.op   = ffha_pkg::OP_FWR;
            state_in = ffha_pkg::S_OUT;
         end
         ffha_pkg::S_OUT: begin
            if (flags.out_free) begin
               cmd.op   = ffha_pkg::OP_OUT;
               state_in = ffha_pkg::S_IDLE;
            end
         end
         default: begin
            state_in = ffha_pkg::S_IDLE;
         end
      endcase
      // A register write rebuilds the heap as one free block.
      if (flags.csr_hit) begin
         state_in = ffha_pkg::S_INIT;
      end
   end

endmodule

### rtl/core/ffha_checker.sv
// Port-level checker of the heap allocator and its bind to the top level.
module ffha_checker (
   input logic        clock,
   input logic        reset,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [87:0] rsp_tdata
);

   // No response survives a reset.
   assert property (@(posedge clock) reset |=> !rsp_tvalid)
      else $error("response valid after reset");

   // A stalled response holds.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("stalled response changed");

   // An address is only granted with an ok status.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[49:2] != 48'd0 |-> rsp_tdata[1:0] == ffha_pkg::ST_OK)
      else $error("address granted with error status");

   // The padding bits above the free total stay zero.
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[87:82] == 6'd0)
      else $error("response padding not zero");

endmodule

bind first_fit_heap_allocator_top ffha_checker u_ffha_checker (
   .clock      (clock),
   .reset      (reset),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);

### tb/first_fit_heap_allocator_top_tb.sv
// Self-checking testbench for the first-fit heap allocator top level.
module first_fit_heap_allocator_top_tb;

   // Geometry of the heap as built in the design.
   localparam int GRANULES   = ffha_pkg::HEAP_GRANULES_DEF;
   localparam int HDR_GRAN   = (ffha_pkg::HEADER_BYTES_DEF + 7) / 8;
   localparam int ADDR_W     = ffha_pkg::ADDR_W;
   localparam int REQ_W      = ffha_pkg::REQ_W;
   localparam int BYTES_W    = ffha_pkg::BYTES_W;
   localparam int CSR_IDX_W  = ffha_pkg::CSR_IDX_W;
   localparam int RSP_PAD    = 88 - (2 + ADDR_W + 2 * BYTES_W);

   // One request as the sender sees it.
   typedef struct {
      logic              mode;
      logic [REQ_W-1:0]  req_bytes;
      logic [ADDR_W-1:0] rel_addr;
   } heap_req_type;

   // One response as the allocator should report it.
   typedef struct {
      ffha_pkg::status_type status;
      logic [ADDR_W-1:0]    granted;
      logic [BYTES_W-1:0]   used;
      logic [BYTES_W-1:0]   free;
   } heap_rsp_type;

   logic clock = 1'b0;
   logic reset = 1'b1;

   logic                 req_tvalid = 1'b0;
   logic                 req_tready;
   logic [79:0]          req_tdata  = '0;  // request_bytes, release_address
   logic                 req_tuser  = 1'b0; // mode
   logic                 rsp_tvalid;
   logic                 rsp_tready = 1'b0;
   logic [87:0]          rsp_tdata;        // status, granted_address, used_bytes, free_bytes
   logic                 csr_valid  = 1'b0;
   logic                 csr_ready;
   logic [CSR_IDX_W-1:0] csr_index  = '0;
   logic [ADDR_W-1:0]    csr_data   = '0;

   first_fit_heap_allocator_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .csr_valid  (csr_valid),
      .csr_ready  (csr_ready),
      .csr_index  (csr_index),
      .csr_data   (csr_data)
   );

   // Two time units per clock period.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // ------------------------------------------------------------------
   // Shadow heap. It mirrors the block table, the used total and the two
   // registers so that every accepted request can be answered in advance.
   // ------------------------------------------------------------------
   bit                     blk_start [GRANULES];
   bit                     blk_used  [GRANULES];
   int unsigned            blk_size  [GRANULES];
   int unsigned            heap_used;
   logic [ADDR_W-1:0]      base_reg;
   logic [BYTES_W-1:0]     bytes_reg;
   longint unsigned        gran_total;
   bit                     heap_enabled;

   heap_rsp_type           pending_rsp_q[$];  // responses still owed by the design
   heap_req_type           request_q[$];      // requests not yet offered
   logic [ADDR_W-1:0]      live_blocks[$];    // addresses handed out and not freed
   logic [ADDR_W-1:0]      freed_blocks[$];   // addresses already given back
   int                     error_count = 0;
   bit                     hold_feed   = 1'b0;

   // Rebuild the shadow heap as one free block, as a register write does.
   function automatic void rebuild_heap();
      longint unsigned cap;
      cap = bytes_reg;
      if (cap > GRANULES * 8) cap = GRANULES * 8;
      for (int i = 0; i < GRANULES; i++) begin
         blk_start[i] = 1'b0;
         blk_used[i]  = 1'b0;
         blk_size[i]  = 0;
      end
      heap_used    = 0;
      heap_enabled = (cap >= 2 * ffha_pkg::HEADER_BYTES_DEF) && ((cap >> 3) > 0);
      gran_total   = heap_enabled ? (cap >> 3) : 0;
      if (heap_enabled) begin
         blk_start[0] = 1'b1;
         blk_size[0]  = int'(gran_total);
      end
      live_blocks.delete();
      freed_blocks.delete();
   endfunction

   // First-fit allocation with split of a large enough remainder.
   function automatic ffha_pkg::status_type alloc_block(input logic [REQ_W-1:0] req,
                                                        output logic [ADDR_W-1:0] addr);
      longint unsigned need;
      longint unsigned g;
      longint unsigned nxt;
      addr = '0;
      g    = 0;
      if (req == 0) return ffha_pkg::ST_ZERO;
      if (!heap_enabled) return ffha_pkg::ST_NO_MEM;
      need = ((longint'(req) + 7) >> 3) + HDR_GRAN;
      while (g < gran_total) begin
         if (blk_size[g] == 0) break;
         if (!blk_used[g] && blk_size[g] >= need) begin
            if (blk_size[g] >= need + HDR_GRAN + 1) begin
               nxt            = g + need;
               blk_start[nxt] = 1'b1;
               blk_used[nxt]  = 1'b0;
               blk_size[nxt]  = blk_size[g] - int'(need);
               blk_size[g]    = int'(need);
            end
            blk_used[g] = 1'b1;
            heap_used  += blk_size[g] * 8;
            addr        = base_reg + ADDR_W'((g + HDR_GRAN) * 8);
            return ffha_pkg::ST_OK;
         end
         g += blk_size[g];
      end
      return ffha_pkg::ST_NO_MEM;
   endfunction

   // Release a block, then merge it with a free successor and a free predecessor.
   function automatic ffha_pkg::status_type release_block(input logic [ADDR_W-1:0] addr);
      logic [ADDR_W-1:0] off;
      longint unsigned   gi, tgt, nxt;
      longint unsigned   g, prev;
      bit                has_prev;
      g        = 0;
      prev     = 0;
      has_prev = 1'b0;
      if (addr == 0) return ffha_pkg::ST_OK;
      if (!heap_enabled) return ffha_pkg::ST_BAD_ADR;
      off = addr - base_reg;
      if (off[2:0] != 3'd0) return ffha_pkg::ST_BAD_ADR;
      gi = longint'(off >> 3);
      if (gi < HDR_GRAN) return ffha_pkg::ST_BAD_ADR;
      tgt = gi - HDR_GRAN;
      if (tgt >= gran_total) return ffha_pkg::ST_BAD_ADR;
      while (g < tgt) begin
         if (blk_size[g] == 0) return ffha_pkg::ST_BAD_ADR;
         prev     = g;
         has_prev = 1'b1;
         g       += blk_size[g];
      end
      if (g != tgt || !blk_start[tgt]) return ffha_pkg::ST_BAD_ADR;
      if (!blk_used[tgt]) return ffha_pkg::ST_OK;
      blk_used[tgt] = 1'b0;
      heap_used    -= blk_size[tgt] * 8;
      nxt = tgt + blk_size[tgt];
      if (nxt < gran_total && blk_start[nxt] && !blk_used[nxt]) begin
         blk_size[tgt] += blk_size[nxt];
         blk_start[nxt] = 1'b0;
         blk_size[nxt]  = 0;
      end
      if (has_prev && !blk_used[prev]) begin
         blk_size[prev] += blk_size[tgt];
         blk_start[tgt]  = 1'b0;
         blk_size[tgt]   = 0;
      end
      return ffha_pkg::ST_OK;
   endfunction

   // Work out the response to one accepted request and queue it.
   function automatic void predict_response(input heap_req_type rq);
      heap_rsp_type rs;
      rs.granted = '0;
      if (rq.mode == ffha_pkg::MODE_FREE) begin
         rs.status = release_block(rq.rel_addr);
      end else begin
         rs.status = alloc_block(rq.req_bytes, rs.granted);
         if (rs.status == ffha_pkg::ST_OK) live_blocks.push_back(rs.granted);
      end
      rs.used = BYTES_W'(heap_used);
      rs.free = heap_enabled ? BYTES_W'(gran_total * 8 - heap_used) : '0;
      pending_rsp_q.push_back(rs);
   endfunction

   // ------------------------------------------------------------------
   // Request driver. It sends in bursts of random length and pauses for
   // random gaps; a request stays on the bus until its transfer happens.
   // ------------------------------------------------------------------
   heap_req_type cur_req;
   int           burst_left = 5;
   int           gap_left   = 0;

   always @(posedge clock) begin
      if (reset) begin
         req_tvalid <= 1'b0;
      end else begin
         if (req_tvalid && req_tready) predict_response(cur_req);
         if (!req_tvalid || req_tready) begin
            if (gap_left > 0) begin
               gap_left--;
               req_tvalid <= 1'b0;
            end else if (!hold_feed && request_q.size() > 0) begin
               cur_req    = request_q.pop_front();
               req_tdata  <= {cur_req.rel_addr, cur_req.req_bytes};
               req_tuser  <= cur_req.mode;
               req_tvalid <= 1'b1;
               burst_left--;
               if (burst_left <= 0) begin
                  burst_left = $urandom_range(1, 30);
                  gap_left   = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 20);
               end
            end else begin
               req_tvalid <= 1'b0;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Response monitor. Ready follows a pattern that steps in turn through
   // four modes: always ready, coin flips, rare ready, alternating.
   // ------------------------------------------------------------------
   int unsigned cycle_count = 0;

   always @(posedge clock) begin
      heap_rsp_type       exp_rsp;
      logic [1:0]         got_status;
      logic [ADDR_W-1:0]  got_granted;
      logic [BYTES_W-1:0] got_used;
      logic [BYTES_W-1:0] got_free;
      cycle_count++;
      case ((cycle_count / 300) % 4)
         0: begin
            rsp_tready <= 1'b1;
         end
         1: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         2: begin
            rsp_tready <= ($urandom_range(0, 4) == 0);
         end
         default: begin
            rsp_tready <= cycle_count[0];
         end
      endcase
      if (!reset && rsp_tvalid && rsp_tready) begin
         {got_free, got_used, got_granted, got_status} = rsp_tdata[87-RSP_PAD:0];
         if (pending_rsp_q.size() == 0) begin
            $error("response transfer with no request outstanding: %h", rsp_tdata);
            error_count++;
         end else begin
            exp_rsp = pending_rsp_q.pop_front();
            if (got_status != exp_rsp.status) begin
               $error("status: expected %0d, got %0d", exp_rsp.status, got_status);
               error_count++;
            end
            if (got_granted != exp_rsp.granted) begin
               $error("granted_address: expected %h, got %h", exp_rsp.granted, got_granted);
               error_count++;
            end
            if (got_used != exp_rsp.used) begin
               $error("used_bytes: expected %0d, got %0d", exp_rsp.used, got_used);
               error_count++;
            end
            if (got_free != exp_rsp.free) begin
               $error("free_bytes: expected %0d, got %0d", exp_rsp.free, got_free);
               error_count++;
            end
         end
      end
   end

   // ------------------------------------------------------------------
   // Stimulus helpers.
   // ------------------------------------------------------------------
   task automatic push_alloc(input logic [REQ_W-1:0] nbytes);
      heap_req_type rq;
      rq.mode      = ffha_pkg::MODE_ALLOC;
      rq.req_bytes = nbytes;
      rq.rel_addr  = ADDR_W'($urandom()) ^ (ADDR_W'($urandom()) << 32);
      request_q.push_back(rq);
   endtask

   task automatic push_free(input logic [ADDR_W-1:0] addr);
      heap_req_type rq;
      rq.mode      = ffha_pkg::MODE_FREE;
      rq.req_bytes = $urandom();
      rq.rel_addr  = addr;
      request_q.push_back(rq);
   endtask

   // Wait until every request has gone out and every response has come back.
   task automatic wait_idle();
      do @(negedge clock);
      while (request_q.size() != 0 || req_tvalid || pending_rsp_q.size() != 0);
      repeat (20) @(negedge clock);
   endtask

   // Register writes happen only while the allocator is idle.
   task automatic write_csr(input logic [CSR_IDX_W-1:0] idx, input logic [ADDR_W-1:0] val);
      @(posedge clock);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data  <= val;
      do @(posedge clock);
      while (!csr_ready);
      csr_valid <= 1'b0;
      if (idx == ffha_pkg::CSR_HEAP_BASE) base_reg = {val[ADDR_W-1:3], 3'b000};
      else bytes_reg = val[BYTES_W-1:0];
      rebuild_heap();
   endtask

   function automatic logic [REQ_W-1:0] random_size();
      int unsigned pick;
      pick = $urandom_range(0, 99);
      if (pick < 45) return $urandom_range(1, 64);
      if (pick < 75) return $urandom_range(65, 512);
      if (pick < 90) return $urandom_range(513, 4096);
      if (pick < 95) return $urandom_range(4097, 40000);
      if (pick < 98) return $urandom();
      return '0;
   endfunction

   // Random traffic: mostly allocations and frees of live blocks, with some
   // double frees, null frees and malformed addresses mixed in.
   task automatic random_traffic(input int count, input int max_size);
      int unsigned       pick;
      int                idx;
      logic [ADDR_W-1:0] addr;
      for (int n = 0; n < count; n++) begin
         while (request_q.size() > 1) @(negedge clock);
         pick = $urandom_range(0, 99);
         if (live_blocks.size() == 0 || pick < (live_blocks.size() > 60 ? 30 : 55)) begin
            if (max_size > 0) push_alloc($urandom_range(0, max_size));
            else push_alloc(random_size());
         end else begin
            pick = $urandom_range(0, 99);
            idx  = $urandom_range(0, live_blocks.size() - 1);
            if (pick < 70) begin
               addr = live_blocks[idx];
               live_blocks.delete(idx);
               freed_blocks.push_back(addr);
            end else if (pick < 78 && freed_blocks.size() > 0) begin
               addr = freed_blocks[$urandom_range(0, freed_blocks.size() - 1)];
            end else if (pick < 83) begin
               addr = '0;
            end else if (pick < 88) begin
               addr = live_blocks[idx] + ADDR_W'($urandom_range(1, 7));
            end else if (pick < 92) begin
               addr = live_blocks[idx] + ADDR_W'(8 * $urandom_range(1, 4));
            end else if (pick < 96) begin
               addr = base_reg + ADDR_W'(8 * $urandom_range(0, HDR_GRAN - 1));
            end else begin
               addr = ADDR_W'($urandom()) ^ (ADDR_W'($urandom()) << 24);
            end
            push_free(addr);
         end
      end
   endtask

   // Short directed sequence: edge sizes, every merge case and the bad frees.
   task automatic directed_checks();
      logic [ADDR_W-1:0] a1, a8, a9, a100, whole;
      push_alloc('0);
      push_alloc('1);
      push_free('0);
      push_alloc(1);
      push_alloc(8);
      push_alloc(9);
      push_alloc(100);
      wait_idle();
      a1   = live_blocks[0];
      a8   = live_blocks[1];
      a9   = live_blocks[2];
      a100 = live_blocks[3];
      live_blocks.delete();
      push_free(a8);     // both neighbors in use
      push_free(a1);     // merges with the free block behind it
      push_free(a100);   // merges with the free tail of the heap
      push_free(a9);     // merges on both sides
      push_free(a9);     // no longer a block start
      wait_idle();
      push_alloc(REQ_W'((gran_total - HDR_GRAN) * 8)); // exact fit of the whole heap
      push_alloc(1);                                   // nothing left
      wait_idle();
      whole = live_blocks.pop_back();
      push_free(whole + 3);
      push_free(base_reg + 8);
      push_free(base_reg + ADDR_W'((gran_total + HDR_GRAN) * 8));
      push_free('1);
      push_free(whole);
      push_free(whole);  // double free of a block that is still a start
      wait_idle();
   endtask

   // ------------------------------------------------------------------
   // Test sequence, phase by phase.
   // ------------------------------------------------------------------
   initial begin
      base_reg  = '0;
      bytes_reg = 16'd32768;
      rebuild_heap();
      repeat (12) @(posedge clock);
      reset <= 1'b0;

      // Full heap at an ordinary base.
      write_csr(ffha_pkg::CSR_HEAP_BASE, 48'h0000_1234_5678);
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 48'd32768);
      directed_checks();
      random_traffic(350, 0);
      // Let every outstanding response come back before sending more.
      hold_feed = 1'b1;
      do @(negedge clock);
      while (pending_rsp_q.size() != 0 || req_tvalid);
      hold_feed = 1'b0;
      random_traffic(350, 0);
      wait_idle();

      // Disabled heaps: zero length and one byte short of two headers.
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 48'd0);
      random_traffic(20, 0);
      wait_idle();
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 48'd63);
      random_traffic(10, 0);
      wait_idle();

      // Smallest heap that is enabled.
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 48'd64);
      push_alloc(32);
      push_alloc(1);
      random_traffic(100, 40);
      wait_idle();

      // Top of the address space with a length above the cap; addresses wrap.
      write_csr(ffha_pkg::CSR_HEAP_BASE, 48'hFFFF_FFFF_FFFF);
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 48'hFFFF_FFFF_FFFF);
      random_traffic(650, 0);
      wait_idle();

      // Random base and a random length that need not be a whole number of granules.
      write_csr(ffha_pkg::CSR_HEAP_BASE, {$urandom(), 16'($urandom())});
      write_csr(ffha_pkg::CSR_HEAP_BYTES, 48'($urandom_range(200, 4000)));
      random_traffic(400, 0);
      wait_idle();

      if (error_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // Watchdog well beyond the slowest legal run.
   initial begin
      #60000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule
